>>> rtl/core/icc_pkg.sv
// Shared constants, command codes and control structures of the coverage counter.
`timescale 1ns / 1ps
`default_nettype none

package icc_pkg;

  // Field widths of the stream and configuration ports.
  localparam int RANGE_W     = 17;
  localparam int LIMIT_W     = 16;
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  // Default store geometry.
  localparam int DEF_POSITIONS  = 65536;
  localparam int DEF_COUNT_BITS = 16;

  // Command codes carried in in_tuser.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WSTART = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEND   = 2'd2;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd12;
  localparam logic [RANGE_W-1:0] WSTART_RST = 17'd0;
  localparam logic [RANGE_W-1:0] WEND_RST   = 17'd65536;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic out_load;
  } icc_ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic out_valid;
  } icc_dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/icc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module icc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/icc_ctrl.sv
// Controller state machine that sequences each command over the count store.
`timescale 1ns / 1ps
`default_nettype none

module icc_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic                    out_tready,
  input  wire icc_pkg::icc_dp_status_t status,
  output icc_pkg::icc_ctrl_cmd_t       cmd
);

  import icc_pkg::*;

  typedef enum logic [4:0] {
    S_WIPE  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SETUP = 5'b00100,
    S_RUN   = 5'b01000,
    S_DONE  = 5'b10000
  } icc_state_t;

  icc_state_t state_r, state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_tready    = 1'b0;
    unique case (state_r)
      S_WIPE: begin
        cmd.step = 1'b1;
        if (status.walk_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (status.walk_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!status.out_valid || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass over the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/icc_dp.sv
// Datapath: configuration registers, range walker, count store and result register.
`timescale 1ns / 1ps
`default_nettype none

module icc_dp #(
  parameter int POSITIONS  = icc_pkg::DEF_POSITIONS,
  parameter int COUNT_BITS = icc_pkg::DEF_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire icc_pkg::icc_ctrl_cmd_t          cmd,
  output icc_pkg::icc_dp_status_t              status,
  input  wire logic [icc_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [icc_pkg::RANGE_W-1:0]     in_start,
  input  wire logic [icc_pkg::RANGE_W-1:0]     in_end,
  input  wire logic                            out_tready,
  output logic                                 out_valid,
  output logic                                 out_full,
  input  wire logic                            cfg_valid,
  input  wire logic [icc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [icc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import icc_pkg::*;

  localparam int ADDR_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int PW     = ($clog2(POSITIONS + 1) > RANGE_W) ? $clog2(POSITIONS + 1) : RANGE_W;
  localparam logic [PW-1:0] POS_LIMIT = PW'(POSITIONS);

  logic [LIMIT_W-1:0]    limit_r;
  logic [RANGE_W-1:0]    wstart_r;
  logic [RANGE_W-1:0]    wend_r;
  logic [CMD_W-1:0]      op_r;
  logic [PW-1:0]         lo_r;
  logic [PW-1:0]         hi_r;
  logic [PW-1:0]         pos_r;
  logic [PW-1:0]         end_r;
  logic                  full_r;
  logic                  rd_pend_r;
  logic [ADDR_W-1:0]     rd_addr_r;
  logic                  out_valid_r;
  logic                  out_full_r;

  logic [RANGE_W-1:0]    lo_clip;
  logic [RANGE_W-1:0]    hi_clip;
  logic [PW-1:0]         end_cap;
  logic                  active;
  logic                  rd_en;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] sat_inc;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      wstart_r <= WSTART_RST;
      wend_r   <= WEND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
        REG_WSTART: wstart_r <= cfg_data[RANGE_W-1:0];
        REG_WEND:   wend_r   <= cfg_data[RANGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Window clipping of the incoming range.
  assign lo_clip = (in_start > wstart_r) ? in_start : wstart_r;
  assign hi_clip = (in_end < wend_r) ? in_end : wend_r;

  // The walk never goes past the end of the store.
  assign end_cap = (hi_r < POS_LIMIT) ? hi_r : POS_LIMIT;

  // One position per step while the walk pointer is below the end.
  assign active = cmd.step && (pos_r < end_r);
  assign rd_en  = active && ((op_r == CMD_ADD) || (op_r == CMD_QUERY));

  // Saturating increment of the count read in the cycle before.
  assign sat_inc = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);

  // Write port: clearing writes zero at the pointer, adds write back behind it.
  always_comb begin
    if (op_r == CMD_CLEAR) begin
      we    = active;
      waddr = pos_r[ADDR_W-1:0];
      wdata = '0;
    end else begin
      we    = rd_pend_r && (op_r == CMD_ADD);
      waddr = rd_addr_r;
      wdata = sat_inc;
    end
  end

  // Control registers of the walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r      <= CMD_CLEAR;
      pos_r     <= '0;
      end_r     <= POS_LIMIT;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      if (cmd.load) begin
        op_r <= in_cmd;
      end
      if (cmd.setup) begin
        unique case (op_r)
          CMD_ADD, CMD_QUERY: begin
            pos_r <= lo_r;
            end_r <= end_cap;
          end
          CMD_CLEAR: begin
            pos_r <= '0;
            end_r <= POS_LIMIT;
          end
          default: begin
            pos_r <= '0;
            end_r <= '0;
          end
        endcase
      end else if (active) begin
        pos_r <= pos_r + PW'(1);
      end
    end
  end

  // Range bounds, read address and the running query verdict.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (in_cmd == CMD_QUERY) begin
        lo_r <= PW'(lo_clip);
        hi_r <= PW'(hi_clip);
      end else begin
        lo_r <= PW'(in_start);
        hi_r <= PW'(in_end);
      end
    end
    if (rd_en) begin
      rd_addr_r <= pos_r[ADDR_W-1:0];
    end
    if (cmd.setup) begin
      // An inverted range fails, and so does any position beyond the store
      // unless the limit is zero.
      full_r <= (op_r == CMD_QUERY) && !(lo_r > hi_r) &&
                !((hi_r > POS_LIMIT) && (lo_r < hi_r) && (limit_r != '0));
    end else if (rd_pend_r && (op_r == CMD_QUERY) && (32'(rd_data) < 32'(limit_r))) begin
      full_r <= 1'b0;
    end
  end

  // Result register, held until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_full_r <= full_r;
    end
  end

  icc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (POSITIONS),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (pos_r[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  assign status.walk_done = (pos_r >= end_r) && !rd_pend_r;
  assign status.out_valid = out_valid_r;
  assign out_valid        = out_valid_r;
  assign out_full         = out_full_r;

endmodule

`default_nettype wire

>>> rtl/core/interval_coverage_counter_unit.sv
// Top level of the per-position coverage depth counter.
//
//   channel  direction  handshake              payload
//   in_      sink       in_tvalid/in_tready    in_tdata, in_tuser (command)
//   out_     source     out_tvalid/out_tready  out_tdata (is_full)
//   cfg_     sink       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An add or query walks the positions of its range that lie inside the store
// and then shows its result; a clear walks the whole store. The count RAM,
// read and written once a cycle, sets the pace of one position a cycle.
// After reset a clearing pass over the store holds in_tready low; configuration
// writes are taken throughout. A new transaction is accepted while the previous
// result waits on out_tready.
`timescale 1ns / 1ps
`default_nettype none

module interval_coverage_counter_unit #(
  parameter int POSITIONS  = icc_pkg::DEF_POSITIONS,
  parameter int COUNT_BITS = icc_pkg::DEF_COUNT_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [16:0] range_start, [33:17] range_end, [39:34] zero
  input  wire logic [icc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  wire logic [icc_pkg::CMD_W-1:0]          in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [0] is_full, [7:1] zero
  output logic      [icc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [icc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [icc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import icc_pkg::*;

  icc_ctrl_cmd_t  cmd;
  icc_dp_status_t status;
  logic           out_full;

  icc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  icc_dp #(
    .POSITIONS  (POSITIONS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_cmd     (in_tuser),
    .in_start   (in_tdata[RANGE_W-1:0]),
    .in_end     (in_tdata[2*RANGE_W-1:RANGE_W]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_full   (out_full),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;
  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, out_full};

endmodule

`default_nettype wire

>>> rtl/core/icc_checker.sv
// Port-level assertions for the coverage counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module icc_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [icc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // Reset starts the clearing pass: no input taken, no result shown.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not quiet after reset");

  // Only one transaction is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a transaction is in work");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Padding above the verdict bit stays zero.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[icc_pkg::OUT_TDATA_W-1:1] == '0))
    else $error("result padding not zero");

endmodule

bind interval_coverage_counter_unit icc_checker u_icc_checker (.*);

`default_nettype wire

>>> tb/tb_interval_coverage_counter_unit.sv
// Self-checking testbench for the per-position coverage depth counter.
`timescale 1ns / 1ps

module tb_interval_coverage_counter_unit;
  import icc_pkg::*;

  localparam int unsigned POSITIONS = DEF_POSITIONS;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int unsigned RAND_PER_PHASE = 186;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 64;
  // The run time of a correct run comes from the clearing pass after reset, a few
  // full-store walks, the odd random clear and small random ranges. The limit
  // allows many times that.
  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  // One row of the directed part: either a register write or a transaction.
  localparam bit ROW_CFG = 1'b1;
  localparam bit ROW_ITEM = 1'b0;
  localparam bit PIN = 1'b1;
  localparam bit FREE = 1'b0;

  typedef struct packed {
    bit               is_cfg;
    logic [1:0]       code;
    logic [16:0]      a;
    logic [16:0]      b;
    bit               pinned;
    bit               full;
  } dir_row_t;

  localparam int DIR_ROWS = 36;
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    // Reset settings: limit 12 over the whole store, all counts zero.
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd0,     PIN,  1'b1},
    '{ROW_ITEM, CMD_QUERY,  17'd5,     17'd10,    PIN,  1'b0},
    '{ROW_ITEM, CMD_UNUSED, 17'd0,     17'd65536, PIN,  1'b0},
    '{ROW_ITEM, CMD_ADD,    17'd10,    17'd5,     PIN,  1'b0},
    '{ROW_ITEM, CMD_ADD,    17'd7,     17'd7,     PIN,  1'b0},
    '{ROW_CFG,  REG_LIMIT,  17'd1,     17'd0,     FREE, 1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd5,     17'd10,    PIN,  1'b0},
    '{ROW_ITEM, CMD_ADD,    17'd0,     17'd65536, PIN,  1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd65536, PIN,  1'b1},
    '{ROW_ITEM, CMD_QUERY,  17'd65535, 17'd65536, PIN,  1'b1},
    '{ROW_CFG,  REG_LIMIT,  17'd2,     17'd0,     FREE, 1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd1,     PIN,  1'b0},
    '{ROW_ITEM, CMD_ADD,    17'd0,     17'd3,     PIN,  1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd3,     FREE, 1'b0},
    // Narrow window: clipped ranges that end up inverted or empty.
    '{ROW_CFG,  REG_WSTART, 17'd100,   17'd0,     FREE, 1'b0},
    '{ROW_CFG,  REG_WEND,   17'd200,   17'd0,     FREE, 1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd300,   17'd400,   PIN,  1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd150,   17'd150,   PIN,  1'b1},
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd50,    PIN,  1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd65536, FREE, 1'b0},
    // The limit register keeps 16 bits, so this write leaves a zero limit.
    '{ROW_CFG,  REG_LIMIT,  17'h10000, 17'd0,     FREE, 1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd100,   17'd200,   PIN,  1'b1},
    '{ROW_CFG,  REG_NONE,   17'd5,     17'd0,     FREE, 1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd120,   17'd130,   PIN,  1'b1},
    '{ROW_CFG,  REG_WSTART, 17'd65536, 17'd0,     FREE, 1'b0},
    '{ROW_CFG,  REG_WEND,   17'd0,     17'd0,     FREE, 1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd65536, PIN,  1'b0},
    '{ROW_CFG,  REG_WSTART, 17'd0,     17'd0,     FREE, 1'b0},
    '{ROW_CFG,  REG_WEND,   17'd65536, 17'd0,     FREE, 1'b0},
    '{ROW_CFG,  REG_LIMIT,  17'd65535, 17'd0,     FREE, 1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd1,     PIN,  1'b0},
    '{ROW_ITEM, CMD_CLEAR,  17'd0,     17'd0,     PIN,  1'b0},
    '{ROW_CFG,  REG_LIMIT,  17'd1,     17'd0,     FREE, 1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd0,     17'd3,     PIN,  1'b0},
    '{ROW_ITEM, CMD_ADD,    17'd65535, 17'd65536, PIN,  1'b0},
    '{ROW_ITEM, CMD_QUERY,  17'd65534, 17'd65536, FREE, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the count store and the registers.
  logic [15:0]   depth_counts [0:POSITIONS-1];
  logic [15:0]   cov_limit = LIMIT_RST;
  logic [16:0]   win_start = WSTART_RST;
  logic [16:0]   win_end = WEND_RST;

  bit            full_due_q [$];
  logic [1:0]    pinned_q [$];
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  bit            rx_hold_req = 1'b0;
  int unsigned   rx_hold_left = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   n_fail = 0;
  int unsigned   n_add = 0, n_query = 0, n_full = 0, n_clear = 0, n_unused = 0;
  int unsigned   n_writes = 0;

  interval_coverage_counter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < POSITIONS; i++) depth_counts[i] = '0;
  end

  // Applies one command to the shadow store and returns the is_full flag.
  function automatic bit apply_coverage_cmd(logic [1:0] cmd, int unsigned s, int unsigned e);
    int unsigned lo, hi, p;
    bit full;
    full = 1'b0;
    case (cmd)
      CMD_ADD: begin
        if (e > POSITIONS) e = POSITIONS;
        for (p = s; p < e; p++) begin
          if (depth_counts[p] != COUNT_MAX) depth_counts[p] = depth_counts[p] + 16'd1;
        end
      end
      CMD_QUERY: begin
        lo = (s > win_start) ? s : win_start;
        hi = (e < win_end) ? e : win_end;
        if (lo <= hi) begin
          full = 1'b1;
          for (p = lo; p < hi && full; p++) begin
            if (((p < POSITIONS) ? depth_counts[p] : 16'd0) < cov_limit) full = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        for (p = 0; p < POSITIONS; p++) depth_counts[p] = '0;
      end
      default: begin
      end
    endcase
    return full;
  endfunction

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("interval_coverage_counter_unit: mismatch");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left != 0) begin
      out_tready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Register writes and accepted transactions update the prediction; each
  // result transaction is checked against the oldest pending flag.
  always @(posedge clk) begin
    logic [1:0] pin;
    bit         predicted;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          REG_LIMIT:  cov_limit = cfg_data[15:0];
          REG_WSTART: win_start = cfg_data;
          REG_WEND:   win_end = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        predicted = apply_coverage_cmd(in_tuser, in_tdata[16:0], in_tdata[33:17]);
        pin = pinned_q.pop_front();
        full_due_q.push_back(pin[1] ? pin[0] : predicted);
        case (in_tuser)
          CMD_ADD:   n_add++;
          CMD_QUERY: begin
            n_query++;
            if (predicted) n_full++;
          end
          CMD_CLEAR: n_clear++;
          default:   n_unused++;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (full_due_q.size() == 0) begin
          n_fail++;
          $display("%0t: result with none pending, actual out_tdata %h", $time, out_tdata);
        end else begin
          predicted = full_due_q.pop_front();
          if (out_tdata !== {7'd0, predicted}) begin
            n_fail++;
            $display("%0t: is_full expected %0d, actual out_tdata %h",
                     $time, predicted, out_tdata);
          end
        end
      end
    end
  end

  // Offers one transaction after a random gap; returns at the falling edge
  // after it is accepted. A pinned flag overrides the predicted one.
  task automatic send_item(logic [1:0] cmd, int unsigned s, int unsigned e,
                           bit pinned, bit full);
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    pinned_q.push_back({pinned, full});
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {6'd0, e[16:0], s[16:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the next transaction or wait lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[16:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    @(negedge clk);
    while (full_due_q.size() != 0) @(negedge clk);
  endtask

  // Draws one random transaction around a region of the store, with some
  // noise, unused commands and the odd clear.
  task automatic pick_item(int unsigned base, output logic [1:0] cmd,
                           output int unsigned s, output int unsigned e);
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r == 0) begin
      cmd = CMD_CLEAR;
      s = $urandom_range(0, 65536);
      e = $urandom_range(0, 65536);
    end else if (r < 8) begin
      cmd = CMD_UNUSED;
      s = $urandom_range(0, 65536);
      e = $urandom_range(0, 65536);
    end else if (r < 22) begin
      // Anywhere in the store, short or inverted so the walk stays cheap.
      cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_ADD;
      s = $urandom_range(0, 65536);
      if ($urandom_range(0, 1)) begin
        e = $urandom_range(0, s);
      end else begin
        e = s + $urandom_range(0, 4);
        if (e > 65536) e = 65536;
      end
    end else if (r < 112) begin
      cmd = CMD_ADD;
      s = base + $urandom_range(0, 255);
      e = s + $urandom_range(0, 48);
    end else begin
      cmd = CMD_QUERY;
      s = base + $urandom_range(0, 255);
      e = s + $urandom_range(0, 24);
    end
  endtask

  initial begin
    int unsigned base, s, e;
    logic [1:0]  cmd;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows; the clearing pass after reset holds the first one off.
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].is_cfg) begin
        settle();
        write_reg(DIR_TABLE[r].code, DIR_TABLE[r].a);
      end else begin
        send_item(DIR_TABLE[r].code, DIR_TABLE[r].a, DIR_TABLE[r].b,
                  DIR_TABLE[r].pinned, DIR_TABLE[r].full);
      end
    end

    // Random phases, each on a fresh region with its own settings.
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 60 : 0;
      rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 21 : 0;
      base = $urandom_range(0, 65536 - 400);
      write_reg(REG_LIMIT, $urandom_range(1, 4));
      if (ph == 0) begin
        write_reg(REG_WSTART, 0);
        write_reg(REG_WEND, 65536);
      end else if (ph == 1) begin
        write_reg(REG_WSTART, base + $urandom_range(0, 64));
        write_reg(REG_WEND, base + $urandom_range(128, 320));
      end else begin
        write_reg(REG_WSTART, base + $urandom_range(0, 300));
        write_reg(REG_WEND, base + $urandom_range(0, 300));
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (ph == 0 && i == 40) rx_hold_req = 1'b1;
        if (ph == 1 && i == 90) settle();
        pick_item(base, cmd, s, e);
        send_item(cmd, s, e, FREE, 1'b0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d adds, %0d queries (%0d full), %0d clears, %0d unused commands",
             n_add, n_query, n_full, n_clear, n_unused);
    $display("and %0d register writes, including window clipping, a zero limit and a long output stall.",
             n_writes);
    if (n_fail == 0 && full_due_q.size() == 0) begin
      $display("interval_coverage_counter_unit: match");
    end else begin
      $display("interval_coverage_counter_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> interval_coverage_counter_unit.f
rtl/core/icc_pkg.sv
rtl/core/icc_ram.sv
rtl/core/icc_ctrl.sv
rtl/core/icc_dp.sv
rtl/core/interval_coverage_counter_unit.sv
rtl/core/icc_checker.sv
tb/tb_interval_coverage_counter_unit.sv
